/* hw/rtl/box_blur_3x3_unit_macros.svh */
// ----------------------------------------------------------------------------
// Box blur 3x3 assertion macros
// Shared property shorthands for the blur pipeline, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_UNIT_MACROS_SVH
`define BOX_BLUR_3X3_UNIT_MACROS_SVH

// Consequence must hold in the same cycle as the antecedent.
`define BB3_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define BB3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/bb3_pkg.sv */
// ----------------------------------------------------------------------------
// Box blur 3x3 package
// Types and constants shared by the line stores, window and divider.
// ----------------------------------------------------------------------------
package bb3_pkg;

  // Line store geometry.
  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);

  // Configuration register widths and reset values.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IMG_W_W    = 11;
  localparam int IMG_H_W    = 16;
  localparam logic [IMG_W_W-1:0] IMG_W_RESET = 11'd640;
  localparam logic [IMG_H_W-1:0] IMG_H_RESET = 16'd480;
  localparam int MIN_DIM = 3;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  // Pixel and arithmetic widths.
  localparam int CHAN_W  = 8;
  localparam int PIX_W   = 3 * CHAN_W;
  localparam int SUM_W   = 12;
  localparam int WIN_TAPS = 6;

  // Reciprocal of nine in 0.16 fixed point; exact for sums up to 9 * 255.
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_9     = 7282;
  localparam int PROD_W      = SUM_W + 13;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [SUM_W-1:0]  sum_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } pixel_t;

  typedef struct packed {
    sum_t red;
    sum_t green;
    sum_t blue;
  } sums_t;

  // Per-pixel control carried from the position counters into the window.
  typedef struct packed {
    logic emit;
    logic frame_end;
  } stage_ctrl_t;

endpackage

/* hw/rtl/bb3_line_ram.sv */
// ----------------------------------------------------------------------------
// Box blur 3x3 line store
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bb3_line_ram #(
  parameter int DATA_W = 24,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/bb3_window.sv */
// ----------------------------------------------------------------------------
// Box blur 3x3 window
// Holds the two previous window columns and registers the per-channel sums
// of the nine neighbors.
// ----------------------------------------------------------------------------
module bb3_window import bb3_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        shift_en,
  input  logic        take,
  input  pixel_t      cur_px,
  input  pixel_t      top_px,
  input  pixel_t      mid_px,
  input  stage_ctrl_t ctrl,
  output logic        b_valid,
  output sums_t       sums,
  output logic        b_frame_end
);

  pixel_t win_r [WIN_TAPS];
  logic   b_valid_r;
  logic   b_valid_nxt;
  sums_t  sums_r;
  sums_t  sums_nxt;
  logic   frame_end_r;

  // Adder tree over the nine samples of one channel.
  function automatic sum_t add9(input chan_t v0, input chan_t v1, input chan_t v2,
                                input chan_t v3, input chan_t v4, input chan_t v5,
                                input chan_t v6, input chan_t v7, input chan_t v8);
    sum_t s01, s23, s45, s67;
    s01 = SUM_W'(v0) + SUM_W'(v1);
    s23 = SUM_W'(v2) + SUM_W'(v3);
    s45 = SUM_W'(v4) + SUM_W'(v5);
    s67 = SUM_W'(v6) + SUM_W'(v7);
    return ((s01 + s23) + (s45 + s67)) + SUM_W'(v8);
  endfunction

  always_comb begin
    sums_nxt.red   = add9(win_r[0].red, win_r[1].red, win_r[2].red, win_r[3].red,
                          win_r[4].red, win_r[5].red, top_px.red, mid_px.red,
                          cur_px.red);
    sums_nxt.green = add9(win_r[0].green, win_r[1].green, win_r[2].green,
                          win_r[3].green, win_r[4].green, win_r[5].green,
                          top_px.green, mid_px.green, cur_px.green);
    sums_nxt.blue  = add9(win_r[0].blue, win_r[1].blue, win_r[2].blue,
                          win_r[3].blue, win_r[4].blue, win_r[5].blue,
                          top_px.blue, mid_px.blue, cur_px.blue);
  end

  // Column shift: taps 0..2 are two columns back, 3..5 one column back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WIN_TAPS; i++) begin
        win_r[i] <= '0;
      end
    end else if (shift_en) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top_px;
      win_r[4] <= mid_px;
      win_r[5] <= cur_px;
    end
  end

  // Sum stage occupancy.
  always_comb begin
    b_valid_nxt = b_valid_r;
    if (shift_en) begin
      b_valid_nxt = ctrl.emit;
    end else if (take) begin
      b_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= b_valid_nxt;
    end
  end

  // Sum payload, loaded only for interior pixels.
  always_ff @(posedge clk) begin
    if (shift_en && ctrl.emit) begin
      sums_r      <= sums_nxt;
      frame_end_r <= ctrl.frame_end;
    end
  end

  assign b_valid     = b_valid_r;
  assign sums        = sums_r;
  assign b_frame_end = frame_end_r;

endmodule

/* hw/rtl/bb3_div9.sv */
// ----------------------------------------------------------------------------
// Box blur 3x3 divider and output register
// Divides each channel sum by nine through a reciprocal multiply and holds
// the result until the output transaction completes.
// ----------------------------------------------------------------------------
module bb3_div9 import bb3_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  load,
  input  sums_t sums,
  input  logic  frame_end,
  output logic  ready,
  output logic  out_valid,
  output chan_t out_red,
  output chan_t out_green,
  output chan_t out_blue,
  output logic  out_frame_end,
  input  logic  out_stall
);

  logic   out_valid_r;
  logic   out_valid_nxt;
  pixel_t res_r;
  pixel_t res_nxt;
  logic   frame_end_r;

  // Truncating divide by nine, exact over the range of a nine-sample sum.
  function automatic chan_t div9(input sum_t s);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(s) * PROD_W'(RECIP_9);
    return prod[RECIP_SHIFT +: CHAN_W];
  endfunction

  always_comb begin
    res_nxt.red   = div9(sums.red);
    res_nxt.green = div9(sums.green);
    res_nxt.blue  = div9(sums.blue);
  end

  // The register can take a new result when empty or being drained.
  assign ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r       <= res_nxt;
      frame_end_r <= frame_end;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red       = res_r.red;
  assign out_green     = res_r.green;
  assign out_blue      = res_r.blue;
  assign out_frame_end = frame_end_r;

endmodule

/* hw/rtl/box_blur_3x3_unit.sv */
// ----------------------------------------------------------------------------
// Box blur 3x3 unit
// Streaming 3x3 box blur over RGB pixels in raster order, using two line
// stores and a registered window; emits one result per interior pixel.
//
//   Channel | Handshake          | Payload
//   --------+--------------------+-----------------------------------------
//   in      | in_valid/in_stall  | in_red, in_green, in_blue
//   out     | out_valid/out_stall| out_red, out_green, out_blue, out_frame_end
//   cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One pixel is accepted every cycle unless an output stall backs up to the
// input; the line store read, the adder tree and the reciprocal multiply
// each take one pipeline stage: read stage, sum register, output register.
// Reset clears the positions, window and stage valids; the line stores are
// not cleared and hold data only once a row has passed through.
// A stall on the output backs up only through stages that are full.
// ----------------------------------------------------------------------------
`include "box_blur_3x3_unit_macros.svh"

module box_blur_3x3_unit import bb3_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // Pixel input
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_red,
  input  logic [7:0]           in_green,
  input  logic [7:0]           in_blue,
  // Blurred output
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_red,
  output logic [7:0]           out_green,
  output logic [7:0]           out_blue,
  output logic                 out_frame_end,
  // Configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [IMG_W_W-1:0] img_w_r;
  logic [IMG_H_W-1:0] img_h_r;
  logic [IMG_W_W-1:0] w_last;
  logic [IMG_H_W-1:0] h_last;

  logic [COL_W-1:0]   col_r;
  logic [COL_W-1:0]   col_nxt;
  logic [IMG_H_W-1:0] row_r;
  logic [IMG_H_W-1:0] row_nxt;
  logic               row_end;
  stage_ctrl_t        ctrl_nxt;

  logic               a_valid_r;
  logic               a_valid_nxt;
  pixel_t             a_px_r;
  logic [COL_W-1:0]   a_col_r;
  stage_ctrl_t        a_ctrl_r;

  logic               in_accept;
  logic               en_a;
  logic               en_b;
  logic               move_a;
  logic               b_valid;
  logic               b_frame_end;
  logic               take_b;
  logic               div_ready;
  sums_t              sums;
  pixel_t             top_px;
  pixel_t             mid_px;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= IMG_W_RESET;
      img_h_r <= IMG_H_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  img_w_r <= cfg_data[IMG_W_W-1:0];
        CFG_IMAGE_HEIGHT: img_h_r <= cfg_data[IMG_H_W-1:0];
        default: ;
      endcase
    end
  end

  // Last column and row after clamping the configured dimensions.
  always_comb begin
    if (img_w_r < IMG_W_W'(MIN_DIM)) begin
      w_last = IMG_W_W'(MIN_DIM - 1);
    end else if (img_w_r > IMG_W_W'(MAX_WIDTH)) begin
      w_last = IMG_W_W'(MAX_WIDTH - 1);
    end else begin
      w_last = img_w_r - IMG_W_W'(1);
    end
    if (img_h_r < IMG_H_W'(MIN_DIM)) begin
      h_last = IMG_H_W'(MIN_DIM - 1);
    end else begin
      h_last = img_h_r - IMG_H_W'(1);
    end
  end

  // Pipeline enables: a stage moves when the one after it has room.
  assign en_b      = !b_valid || div_ready;
  assign move_a    = a_valid_r && en_b;
  assign take_b    = b_valid && div_ready;
  assign en_a      = !a_valid_r || en_b;
  assign in_stall  = !en_a;
  assign in_accept = in_valid && en_a;

  // Position of the incoming pixel and its row and frame flags.
  always_comb begin
    row_end            = IMG_W_W'(col_r) >= w_last;
    ctrl_nxt.emit      = (row_r >= IMG_H_W'(2)) && (col_r >= COL_W'(2));
    ctrl_nxt.frame_end = row_end && (row_r >= h_last);
    col_nxt            = col_r;
    row_nxt            = row_r;
    if (in_accept) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = (row_r >= h_last) ? '0 : row_r + IMG_H_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Read stage: holds the pixel while the line stores answer.
  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_accept) begin
      a_valid_nxt = 1'b1;
    end else if (move_a) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_px_r   <= '{red: in_red, green: in_green, blue: in_blue};
      a_col_r  <= col_r;
      a_ctrl_r <= ctrl_nxt;
    end
  end

  // Line stores: read at accept, written back as the pixel leaves the read
  // stage. A column is read again only a full row later, after its write.
  bb3_line_ram #(
    .DATA_W (PIX_W),
    .DEPTH  (MAX_WIDTH)
  ) u_older_line (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (col_r),
    .rd_data (top_px),
    .wr_en   (move_a),
    .wr_addr (a_col_r),
    .wr_data (mid_px)
  );

  bb3_line_ram #(
    .DATA_W (PIX_W),
    .DEPTH  (MAX_WIDTH)
  ) u_newer_line (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (col_r),
    .rd_data (mid_px),
    .wr_en   (move_a),
    .wr_addr (a_col_r),
    .wr_data (a_px_r)
  );

  // Window and neighborhood sums.
  bb3_window u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .shift_en    (move_a),
    .take        (take_b),
    .cur_px      (a_px_r),
    .top_px      (top_px),
    .mid_px      (mid_px),
    .ctrl        (a_ctrl_r),
    .b_valid     (b_valid),
    .sums        (sums),
    .b_frame_end (b_frame_end)
  );

  // Divide by nine and output register.
  bb3_div9 u_div9 (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (take_b),
    .sums          (sums),
    .frame_end     (b_frame_end),
    .ready         (div_ready),
    .out_valid     (out_valid),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_frame_end (out_frame_end),
    .out_stall     (out_stall)
  );

  // Assertions on the pipeline control.
  `BB3_ASSERT_NOW(a_empty_no_stall, !a_valid_r, !in_stall, "input stalled with read stage empty")
  `BB3_ASSERT_NEXT(emit_fills_sum, move_a && a_ctrl_r.emit, b_valid, "interior pixel lost at sum stage")
  `BB3_ASSERT_NEXT(row_end_wraps, in_accept && row_end, col_r == '0, "column did not wrap at row end")
  `BB3_ASSERT_NEXT(take_fills_out, take_b, out_valid, "sum handed off without an output result")

endmodule

/* sim/box_blur_3x3_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Box blur 3x3 unit testbench
// Streams RGB frames through the blur unit with random input gaps and output
// stalls. A behavioral line-store model predicts every blurred pixel, and each
// output transaction is checked against the oldest pending prediction. The
// run covers a partial row at the reset geometry, flat and bit-pattern frames,
// clamped and maximum widths, a tall frame cut short, mid-frame reshaping and
// random frames.
// ----------------------------------------------------------------------------
module box_blur_3x3_unit_test import bb3_pkg::*; ();

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_PAD      = 12;
  localparam int MAX_REPORTS    = 10;
  localparam int RESET_PIXELS   = 16;
  localparam int RANDOM_PIXELS  = 150;
  localparam int CALM_TAIL      = 60;
  localparam int NEIGHBORS      = 9;

  // Indexes that decode to no register; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  frame_end;
  } blur_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_red    = '0;
  logic [7:0]            in_green  = '0;
  logic [7:0]            in_blue   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            out_red;
  logic [7:0]            out_green;
  logic [7:0]            out_blue;
  logic                  out_frame_end;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Behavioral copy of the block state and its registers.
  logic [IMG_W_W-1:0] width_reg;
  logic [IMG_H_W-1:0] height_reg;
  pixel_t             line_two_up [MAX_WIDTH];
  pixel_t             line_one_up [MAX_WIDTH];
  pixel_t             window_px [WIN_TAPS];
  int unsigned        col_pos;
  int unsigned        row_pos;

  blur_t pending_blurs[$];
  int    err_count   = 0;
  bit    idling      = 1'b1;
  int    stall_left  = 0;
  int    idle_cycles = 0;

  box_blur_3x3_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_frame_end(out_frame_end),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Output stalls come in short random bursts while idling is enabled.
  always @(negedge clk) begin
    if (stall_left > 0)
      stall_left--;
    else if (idling && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 3);
    out_stall <= (stall_left > 0);
  end

  // Each output transaction is compared with the oldest pending blur.
  always @(posedge clk) begin : result_check
    blur_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_blurs.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("unexpected result: red %0d green %0d blue %0d frame_end %0b",
                   out_red, out_green, out_blue, out_frame_end);
      end else begin
        want = pending_blurs.pop_front();
        if (out_red !== want.red || out_green !== want.green ||
            out_blue !== want.blue || out_frame_end !== want.frame_end) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display({"mismatch: expected r %0d g %0d b %0d end %0b, ",
                      "got r %0d g %0d b %0d end %0b"},
                     want.red, want.green, want.blue, want.frame_end,
                     out_red, out_green, out_blue, out_frame_end);
        end
      end
    end
  end

  // The watchdog ends a run in which no channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  // Effective row length: the width register clamped to at least three and to the line store size.
  function automatic int unsigned eff_width();
    if (width_reg < MIN_DIM)
      return MIN_DIM;
    if (width_reg > MAX_WIDTH)
      return MAX_WIDTH;
    return int'(width_reg);
  endfunction

  // Advance the model by one pixel and queue the blur it completes, if any.
  task automatic predict_blur(input pixel_t px);
    int unsigned w, h, c;
    int unsigned sum_r, sum_g, sum_b;
    pixel_t      top, mid;
    pixel_t      hood [NEIGHBORS];
    logic        row_end;
    blur_t       res;
    w = eff_width();
    h = (height_reg < MIN_DIM) ? MIN_DIM : int'(height_reg);
    c = (col_pos >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_pos;
    top = line_two_up[c];
    mid = line_one_up[c];
    row_end = (c >= w - 1);

    // Interior pixel one row up and one column left is now complete.
    if (row_pos >= 2 && c >= 2) begin
      for (int k = 0; k < WIN_TAPS; k++)
        hood[k] = window_px[k];
      hood[6] = top;
      hood[7] = mid;
      hood[8] = px;
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      for (int k = 0; k < NEIGHBORS; k++) begin
        sum_r += hood[k].red;
        sum_g += hood[k].green;
        sum_b += hood[k].blue;
      end
      res.red       = chan_t'(sum_r / NEIGHBORS);
      res.green     = chan_t'(sum_g / NEIGHBORS);
      res.blue      = chan_t'(sum_b / NEIGHBORS);
      res.frame_end = (row_pos >= h - 1) && row_end;
      pending_blurs.push_back(res);
    end

    // Shift the window and update both line stores.
    for (int k = 0; k < 3; k++)
      window_px[k] = window_px[k + 3];
    window_px[3] = top;
    window_px[4] = mid;
    window_px[5] = px;
    line_two_up[c] = mid;
    line_one_up[c] = px;

    if (row_end) begin
      col_pos = 0;
      row_pos = (row_pos >= h - 1) ? 0 : row_pos + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  // Random pixel with channels biased toward their extremes.
  function automatic pixel_t rand_pixel();
    logic [PIX_W-1:0] bits;
    for (int k = 0; k < 3; k++)
      case ($urandom_range(0, 5))
        0:       bits[k*CHAN_W +: CHAN_W] = '0;
        1:       bits[k*CHAN_W +: CHAN_W] = '1;
        default: bits[k*CHAN_W +: CHAN_W] = CHAN_W'($urandom_range(0, 255));
      endcase
    return pixel_t'(bits);
  endfunction

  // Send one pixel transaction, optionally after a short gap.
  task automatic send_pixel(input pixel_t px);
    @(negedge clk);
    if (idling && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= px.red;
    in_green <= px.green;
    in_blue  <= px.blue;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_blur(px);
  endtask

  // Write one configuration register; the block must be idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_IMAGE_WIDTH:  width_reg = data[IMG_W_W-1:0];
      CFG_IMAGE_HEIGHT: height_reg = data[IMG_H_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stop sending and let the pipeline empty out.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_blurs.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  // Send random pixels until the frame wraps back to its first pixel.
  task automatic finish_frame();
    do
      send_pixel(rand_pixel());
    while (row_pos != 0 || col_pos != 0);
  endtask

  // A partial row at the reset geometry, then a mid-row shrink ends that row
  // and a three-row frame follows.
  task automatic test_reset_geometry();
    repeat (RESET_PIXELS) send_pixel(rand_pixel());
    settle();
    write_reg(CFG_IMAGE_WIDTH, 16'd5);
    write_reg(CFG_IMAGE_HEIGHT, 16'd3);
    finish_frame();
    settle();
  endtask

  // Smallest frames: all ones, all zeros and alternating bit patterns.
  task automatic test_flat_frames();
    write_reg(CFG_IMAGE_WIDTH, 16'd3);
    write_reg(CFG_IMAGE_HEIGHT, 16'd3);
    repeat (NEIGHBORS) send_pixel('1);
    repeat (NEIGHBORS) send_pixel('0);
    for (int k = 0; k < NEIGHBORS; k++)
      send_pixel((k % 2) ? pixel_t'({3{8'h55}}) : pixel_t'({3{8'hAA}}));
    settle();
  endtask

  // Width and height below the minimum are treated as three.
  task automatic test_clamped_geometry();
    write_reg(CFG_IMAGE_WIDTH, 16'd0);
    write_reg(CFG_IMAGE_HEIGHT, 16'd0);
    finish_frame();
    settle();
    write_reg(CFG_IMAGE_WIDTH, 16'd2);
    write_reg(CFG_IMAGE_HEIGHT, 16'd2);
    finish_frame();
    settle();
  endtask

  // Unused indexes are ignored; an oversized width clamps to the line store,
  // so one full row wraps at its last column before the frame narrows.
  task automatic test_max_width();
    write_reg(CFG_SPARE_A, 16'hFFFF);
    write_reg(CFG_SPARE_B, 16'h0000);
    write_reg(CFG_IMAGE_WIDTH, 16'hFFFF);
    write_reg(CFG_IMAGE_HEIGHT, 16'd3);
    repeat (MAX_WIDTH) send_pixel(rand_pixel());
    settle();
    write_reg(CFG_IMAGE_WIDTH, 16'd5);
    finish_frame();
    settle();
  endtask

  // Tallest height, cut short by lowering the height mid-frame.
  task automatic test_tall_frame();
    write_reg(CFG_IMAGE_WIDTH, 16'd4);
    write_reg(CFG_IMAGE_HEIGHT, 16'hFFFF);
    repeat (6 * 4) send_pixel(rand_pixel());
    settle();
    write_reg(CFG_IMAGE_HEIGHT, 16'd3);
    finish_frame();
    settle();
  endtask

  // Random small frames, some reshaped at a row boundary.
  task automatic test_random_frames();
    int sent;
    bit reshaped;
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      if ($urandom_range(0, 3) != 0)
        case ($urandom_range(0, 9))
          0:       write_reg(CFG_IMAGE_WIDTH, 16'($urandom_range(0, 2)));
          1:       write_reg(CFG_IMAGE_WIDTH, 16'($urandom_range(13, 40)));
          default: write_reg(CFG_IMAGE_WIDTH, 16'($urandom_range(3, 12)));
        endcase
      if ($urandom_range(0, 3) != 0)
        case ($urandom_range(0, 7))
          0:       write_reg(CFG_IMAGE_HEIGHT, 16'($urandom_range(0, 2)));
          default: write_reg(CFG_IMAGE_HEIGHT, 16'($urandom_range(3, 6)));
        endcase
      reshaped = 1'b0;
      do begin
        // Only shrink the width mid-frame so every line store read was written.
        if (!reshaped && col_pos == 0 && row_pos >= 1 && $urandom_range(0, 7) == 0) begin
          settle();
          if ($urandom_range(0, 1))
            write_reg(CFG_IMAGE_WIDTH, 16'($urandom_range(0, eff_width())));
          else
            write_reg(CFG_IMAGE_HEIGHT, 16'($urandom_range(0, 8)));
          reshaped = 1'b1;
        end
        send_pixel(rand_pixel());
        sent++;
        if (sent >= RANDOM_PIXELS - CALM_TAIL)
          idling = 1'b0;
      end while (row_pos != 0 || col_pos != 0);
      settle();
    end
  endtask

  initial begin
    width_reg  = IMG_W_RESET;
    height_reg = IMG_H_RESET;
    col_pos    = 0;
    row_pos    = 0;
    for (int k = 0; k < MAX_WIDTH; k++) begin
      line_two_up[k] = '0;
      line_one_up[k] = '0;
    end
    for (int k = 0; k < WIN_TAPS; k++)
      window_px[k] = '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_geometry();
    test_flat_frames();
    test_clamped_geometry();
    test_max_width();
    test_tall_frame();
    test_random_frames();
    settle();

    if (err_count == 0 && pending_blurs.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
